// File: hw/rtl/command_frame_deframer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command frame deframer
// Clocked, reset-qualified property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CFD_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cfd_pkg.sv
// ---------------------------------------------------------------------------
// cfd_pkg
// Constants, codes, control structs and the float conversion of the deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam int LEN_MAX          = FRAME_BYTES - 5;

  // Byte positions within a frame.
  localparam int POS_HDR0       = 0;
  localparam int POS_HDR1       = 1;
  localparam int POS_LEN        = 3;
  localparam int SUM_BASE       = 4;
  localparam int POS_START_WORD = 4;
  localparam int POS_INIT_WORD  = 44;
  localparam int WORD_BYTES     = 4;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  localparam logic [3:0] KIND_START   = 4'd0;
  localparam logic [3:0] KIND_MODE    = 4'd1;
  localparam logic [3:0] KIND_ANGLE_A = 4'd2;
  localparam logic [3:0] KIND_VEL_D   = 4'd9;
  localparam logic [3:0] KIND_VEL_X   = 4'd10;
  localparam logic [3:0] KIND_VEL_Z   = 4'd12;
  localparam logic [3:0] KIND_INIT    = 4'd13;

  localparam logic [7:0] MODE_FULL  = 8'd0;
  localparam logic [7:0] MODE_VEL   = 8'd1;

  typedef struct packed {
    logic wr_byte;
    logic close;
    logic walk;
    logic start_words;
    logic wstep;
    logic load_item;
    logic load_bad;
    logic next_word;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    chk_done;
    status_t chk_status;
    logic    word_done;
    logic    out_last;
  } dp_stat_t;

  // Single-precision bits to an integer, truncated and saturated to 0..255.
  function automatic logic [7:0] float_to_u8(input logic [31:0] bits);
    logic [7:0]  expf;
    logic [22:0] mant;
    logic [4:0]  sh;
    logic [23:0] full;
    logic [7:0]  res;
    expf = bits[30:23];
    mant = bits[22:0];
    sh   = 5'(8'd150 - expf);
    full = {1'b1, mant} >> sh;
    if (expf == 8'hFF && mant != 23'd0) begin
      res = 8'd0;
    end else if (bits[31]) begin
      res = 8'd0;
    end else if (expf < 8'd127) begin
      res = 8'd0;
    end else if (expf >= 8'd135) begin
      res = 8'd255;
    end else begin
      res = full[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cfd_in_if.sv
// ---------------------------------------------------------------------------
// cfd_in_if
// Input channel: received bytes and idle-line marks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfd_out_if.sv
// ---------------------------------------------------------------------------
// cfd_out_if
// Output channel: decoded frame items and frame counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  item_kind;
  logic [31:0] item_value;
  logic        last;
  logic [31:0] frames_received;
  logic [31:0] frames_valid;
  logic [31:0] frames_bad;

  modport source (output valid, output status, output item_kind, output item_value,
                  output last, output frames_received, output frames_valid,
                  output frames_bad, input ready);
  modport sink   (input valid, input status, input item_kind, input item_value,
                  input last, input frames_received, input frames_valid,
                  input frames_bad, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cfd_datapath.sv
// ---------------------------------------------------------------------------
// cfd_datapath
// Frame store, checksum walk, word assembly, output register and counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  cfd_pkg::ctrl_cmd_t cmd,
  output cfd_pkg::dp_stat_t  stat,
  input  logic [7:0]         in_byte,
  output cfd_pkg::status_t   status,
  output logic [3:0]         item_kind,
  output logic [31:0]        item_value,
  output logic               last,
  output logic [31:0]        frames_received,
  output logic [31:0]        frames_valid,
  output logic [31:0]        frames_bad
);
  import cfd_pkg::*;

  logic [7:0]        mem [FRAME_BYTES];
  logic              vld [FRAME_BYTES];
  logic [7:0]        rd_byte;
  logic              rd_vld;

  logic [POS_W-1:0]  wr_pos;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] base_next;
  logic [1:0]        bcnt;
  logic [7:0]        sum;
  logic [7:0]        len;
  logic              hdr0;
  logic              hdr1;
  logic [23:0]       word_lo;
  logic [3:0]        kind;
  logic [3:0]        kind_next;
  logic [7:0]        mode;

  logic [7:0]        d;
  logic [8:0]        end_pos;
  logic [8:0]        j9;
  logic              at_len;
  logic              at_end;
  logic              hdr_bad;
  logic              len_bad;
  logic              wr_ok;
  logic [31:0]       word_full;
  logic [7:0]        conv;

  // Entries never written since reset read as zero.
  assign d         = rd_vld ? rd_byte : 8'd0;
  assign end_pos   = {1'b0, len} + 9'(SUM_BASE);
  assign j9        = 9'(idx);
  assign at_len    = (idx == ADDR_W'(POS_LEN));
  assign at_end    = (idx > ADDR_W'(POS_LEN)) && (j9 == end_pos);
  assign hdr_bad   = !(hdr0 && hdr1);
  assign len_bad   = ({1'b0, d} > 9'(LEN_MAX));
  assign wr_ok     = (wr_pos < POS_W'(FRAME_BYTES));
  assign word_full = {word_lo, d};
  assign conv      = float_to_u8(word_full);

  always_comb begin
    stat.chk_done   = (at_len && (hdr_bad || len_bad)) || at_end;
    if (at_len) begin
      stat.chk_status = hdr_bad ? ST_BAD_HDR : ST_BAD_LEN;
    end else begin
      stat.chk_status = (sum == d) ? ST_OK : ST_BAD_SUM;
    end
    stat.word_done  = (bcnt == 2'd3);
    stat.out_last   = last;
  end

  always_comb begin
    base_next = base + ADDR_W'(WORD_BYTES);
    case (kind)
      KIND_MODE: kind_next = (mode == MODE_FULL) ? KIND_ANGLE_A : KIND_VEL_X;
      KIND_VEL_D: kind_next = KIND_INIT;
      KIND_VEL_Z: begin
        kind_next = KIND_INIT;
        base_next = ADDR_W'(POS_INIT_WORD);
      end
      default: kind_next = kind + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte && wr_ok) begin
      mem[wr_pos[ADDR_W-1:0]] <= in_byte;
    end
    rd_byte <= mem[idx];
    rd_vld  <= vld[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        vld[k] <= 1'b0;
      end
      wr_pos          <= '0;
      frames_received <= '0;
      frames_valid    <= '0;
      frames_bad      <= '0;
    end else begin
      if (cmd.wr_byte && wr_ok) begin
        vld[wr_pos[ADDR_W-1:0]] <= 1'b1;
        wr_pos                  <= wr_pos + POS_W'(1);
      end
      if (cmd.close) begin
        wr_pos          <= '0;
        frames_received <= frames_received + 32'd1;
      end
      if (cmd.start_words) begin
        frames_valid <= frames_valid + 32'd1;
      end
      if (cmd.load_bad) begin
        frames_bad <= frames_bad + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      idx <= '0;
      sum <= 8'd0;
    end
    if (cmd.walk) begin
      if (idx == ADDR_W'(POS_HDR0)) hdr0 <= (d == HDR_BYTE);
      if (idx == ADDR_W'(POS_HDR1)) hdr1 <= (d == HDR_BYTE);
      if (at_len) len <= d;
      // The length is not yet known while the fixed leading bytes go by.
      if (idx <= ADDR_W'(POS_LEN) || j9 < end_pos) begin
        sum <= sum + d;
      end
      idx <= idx + ADDR_W'(1);
    end
    if (cmd.start_words) begin
      base <= ADDR_W'(POS_START_WORD);
      idx  <= ADDR_W'(POS_START_WORD);
      kind <= KIND_START;
      bcnt <= 2'd0;
    end
    if (cmd.wstep) begin
      word_lo <= word_full[23:0];
      idx     <= idx + ADDR_W'(1);
      bcnt    <= bcnt + 2'd1;
    end
    if (cmd.next_word) begin
      kind <= kind_next;
      base <= base_next;
      idx  <= base_next;
      bcnt <= 2'd0;
    end
    if (cmd.load_item) begin
      status    <= ST_OK;
      item_kind <= kind;
      if (kind == KIND_START || kind == KIND_MODE) begin
        item_value <= 32'(conv);
      end else begin
        item_value <= word_full;
      end
      last <= (kind == KIND_INIT) ||
              (kind == KIND_MODE && conv != MODE_FULL && conv != MODE_VEL);
      if (kind == KIND_MODE) mode <= conv;
    end
    if (cmd.load_bad) begin
      status     <= stat.chk_status;
      item_kind  <= KIND_START;
      item_value <= 32'd0;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfd_controller.sv
// ---------------------------------------------------------------------------
// cfd_controller
// Sequencer for byte capture, frame check, word reads and result handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfd_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output cfd_pkg::ctrl_cmd_t cmd,
  input  cfd_pkg::dp_stat_t  stat
);
  import cfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREAD,
    S_CDATA,
    S_WREAD,
    S_WDATA,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_cmd == CMD_IDLE) begin
            cmd.close  = 1'b1;
            state_next = S_CREAD;
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end
      end
      S_CREAD: state_next = S_CDATA;
      S_CDATA: begin
        // The walk only advances while the check is still undecided.
        if (!stat.chk_done) begin
          cmd.walk   = 1'b1;
          state_next = S_CREAD;
        end else if (stat.chk_status != ST_OK) begin
          cmd.load_bad = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.start_words = 1'b1;
          state_next      = S_WREAD;
        end
      end
      S_WREAD: state_next = S_WDATA;
      S_WDATA: begin
        cmd.wstep = 1'b1;
        if (stat.word_done) begin
          cmd.load_item = 1'b1;
          state_next    = S_OUT;
        end else begin
          state_next = S_WREAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_word = 1'b1;
            state_next    = S_WREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_OUT);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/command_frame_deframer.sv
// A data byte is written into the frame store and ready stays high between frames.
// An idle-line word starts a check that reads the stored bytes one at a time, each
// fetched in S_CREAD and tested in S_CDATA: len+5 bytes for a good frame, four when
// the header or length fails. Each result word is then read byte by byte and presented;
// each result holds until taken, and ready returns after the last one.
// Reset clears counters, write position and the store's valid bits; unwritten bytes read 0.
// ---------------------------------------------------------------------------
// command_frame_deframer
// Collects received bytes into a frame store and decodes checked frames.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer (
  input  logic      clk,
  input  logic      rst,
  cfd_in_if.sink    in_ch,
  cfd_out_if.source out_ch
);
  import cfd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_t   status;

  cfd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cfd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_byte         (in_ch.rx_byte),
    .status          (status),
    .item_kind       (out_ch.item_kind),
    .item_value      (out_ch.item_value),
    .last            (out_ch.last),
    .frames_received (out_ch.frames_received),
    .frames_valid    (out_ch.frames_valid),
    .frames_bad      (out_ch.frames_bad)
  );

  assign out_ch.status = 2'(status);

endmodule

`default_nettype wire

// File: hw/rtl/cfd_checker.sv
// ---------------------------------------------------------------------------
// cfd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "command_frame_deframer_assert.svh"

module cfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  item_kind,
  input logic [31:0] item_value,
  input logic        last,
  input logic [31:0] frames_received,
  input logic [31:0] frames_valid,
  input logic [31:0] frames_bad
);
  import cfd_pkg::*;

  logic reject_ok;

  assign reject_ok = (status == ST_OK) ||
                     (last && item_kind == KIND_START && item_value == 32'd0);

  // A stalled result keeps its word.
  `CFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(item_value), "stalled result changed")

  // No new word is taken while a result is pending.
  `CFD_ASSERT_ALWAYS(a_no_overlap, clk, rst, !(out_valid && in_ready), "input ready while result pending")

  // A rejected frame gives a single closing start-kind result.
  `CFD_ASSERT_ALWAYS(a_reject_form, clk, rst, !out_valid || reject_ok, "malformed reject result")

  // Every received frame is counted once as valid or bad.
  `CFD_ASSERT_ALWAYS(a_count_sum, clk, rst, !out_valid || (frames_received == 32'(frames_valid + frames_bad)), "frame counters inconsistent")

endmodule

bind command_frame_deframer cfd_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .item_kind       (out_ch.item_kind),
  .item_value      (out_ch.item_value),
  .last            (out_ch.last),
  .frames_received (out_ch.frames_received),
  .frames_valid    (out_ch.frames_valid),
  .frames_bad      (out_ch.frames_bad)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the command frame deframer
// Drives received bytes and idle-line marks with random gaps, predicts every
// decoded item and the frame counters, and checks each word that the block
// emits against the oldest prediction while the sink stalls at random.
// ---------------------------------------------------------------------------

module tb_top;
  import cfd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 200;
  localparam int RANDOM_ITEMS = 130;

  typedef struct {
    status_t     status;
    logic [3:0]  kind;
    logic [31:0] value;
    logic        last;
    logic [31:0] n_received;
    logic [31:0] n_valid;
    logic [31:0] n_bad;
  } frame_item_t;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_HDR,
    SHAPE_BAD_LEN,
    SHAPE_BAD_SUM,
    SHAPE_NOISE
  } frame_shape_t;

  logic clk;
  logic rst;

  cfd_in_if  in_ch ();
  cfd_out_if out_ch ();

  command_frame_deframer uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the block's state.
  logic [7:0]  shadow_store [FRAME_BYTES];
  int          shadow_pos;
  logic [31:0] shadow_received;
  logic [31:0] shadow_valid;
  logic [31:0] shadow_bad;

  frame_item_t pending_items[$];
  logic [7:0]  frame_buf[$];

  int mismatch_count;
  int items_taken;
  int cycle_count;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // IEEE single to integer, truncated toward zero and clamped to 0..255.
  function automatic logic [7:0] trunc_to_byte(input logic [31:0] w);
    logic [7:0]  e;
    logic [23:0] sig;
    e   = w[30:23];
    sig = {1'b1, w[22:0]};
    if (e == 8'hFF && w[22:0] != 23'd0) return 8'd0;
    if (w[31]) return 8'd0;
    if (e < 8'd127) return 8'd0;
    if (e >= 8'd135) return 8'd255;
    return 8'(sig >> (150 - int'(e)));
  endfunction

  function automatic logic [31:0] store_word(input int pos);
    return {shadow_store[pos], shadow_store[pos + 1], shadow_store[pos + 2],
            shadow_store[pos + 3]};
  endfunction

  task automatic queue_item(input status_t st, input logic [3:0] kind,
                            input logic [31:0] value);
    frame_item_t it;
    it.status     = st;
    it.kind       = kind;
    it.value      = value;
    it.last       = 1'b0;
    it.n_received = shadow_received;
    it.n_valid    = shadow_valid;
    it.n_bad      = shadow_bad;
    pending_items.push_back(it);
  endtask

  task automatic predict_frame_items();
    status_t     st;
    int          len;
    logic [7:0]  acc;
    logic [7:0]  mode;
    frame_item_t tail;
    st  = ST_OK;
    acc = 8'd0;
    shadow_pos = 0;
    shadow_received++;
    if (shadow_store[POS_HDR0] != HDR_BYTE || shadow_store[POS_HDR1] != HDR_BYTE) begin
      st = ST_BAD_HDR;
    end else begin
      len = int'(shadow_store[POS_LEN]);
      if (len > LEN_MAX) begin
        st = ST_BAD_LEN;
      end else begin
        for (int i = 0; i < len + SUM_BASE; i++) acc += shadow_store[i];
        if (acc != shadow_store[len + SUM_BASE]) st = ST_BAD_SUM;
      end
    end
    if (st != ST_OK) begin
      shadow_bad++;
      queue_item(st, KIND_START, 32'd0);
    end else begin
      shadow_valid++;
      queue_item(ST_OK, KIND_START, 32'(trunc_to_byte(store_word(POS_START_WORD))));
      mode = trunc_to_byte(store_word(POS_START_WORD + WORD_BYTES));
      queue_item(ST_OK, KIND_MODE, 32'(mode));
      if (mode == MODE_FULL) begin
        for (int i = 0; i < 8; i++)
          queue_item(ST_OK, KIND_ANGLE_A + 4'(i), store_word(12 + WORD_BYTES * i));
        queue_item(ST_OK, KIND_INIT, store_word(POS_INIT_WORD));
      end else if (mode == MODE_VEL) begin
        for (int i = 0; i < 3; i++)
          queue_item(ST_OK, KIND_VEL_X + 4'(i), store_word(12 + WORD_BYTES * i));
        queue_item(ST_OK, KIND_INIT, store_word(POS_INIT_WORD));
      end
    end
    tail = pending_items[pending_items.size() - 1];
    tail.last = 1'b1;
    pending_items[pending_items.size() - 1] = tail;
  endtask

  // Input side: every accepted word updates the shadow state.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      items_taken++;
      if (in_ch.cmd == CMD_IDLE) begin
        predict_frame_items();
      end else if (shadow_pos < FRAME_BYTES) begin
        shadow_store[shadow_pos] = in_ch.rx_byte;
        shadow_pos++;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
  endtask

  // Output side: each accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    frame_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_items.size() == 0) begin
        report_mismatch($sformatf("unexpected word, kind %0d", out_ch.item_kind));
      end else begin
        want = pending_items.pop_front();
        check_field("status", 32'(out_ch.status), 32'(want.status));
        check_field("item_kind", 32'(out_ch.item_kind), 32'(want.kind));
        check_field("item_value", out_ch.item_value, want.value);
        check_field("last", 32'(out_ch.last), 32'(want.last));
        check_field("frames_received", out_ch.frames_received, want.n_received);
        check_field("frames_valid", out_ch.frames_valid, want.n_valid);
        check_field("frames_bad", out_ch.frames_bad, want.n_bad);
      end
    end
  end

  // Sink: random stall before each word, none while no_gaps is set.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_word(input logic cmd, input logic [7:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    repeat (gap) @(negedge clk);
    in_ch.cmd     = cmd;
    in_ch.rx_byte = data;
    in_ch.valid   = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_word(CMD_BYTE, frame_buf[i]);
    send_word(CMD_IDLE, 8'($urandom));
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_float_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0001;
      3:       return 32'h3F80_0000;
      4:       return 32'h437F_0000;
      5:       return 32'h437F_FFFF;
      6:       return 32'h4380_0000;
      7:       return 32'h7F80_0000;
      8:       return 32'hFF80_0000;
      9:       return 32'h7FC0_0000;
      10:      return 32'hC200_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly the two modes that carry target words, sometimes anything.
  function automatic logic [31:0] pick_mode_word();
    case ($urandom_range(0, 7))
      0, 1:    return 32'h0000_0000;
      2, 3:    return 32'h3F80_0000;
      4:       return 32'h3FFF_FFFF;
      5:       return 32'h3F7F_FFFF;
      6:       return 32'h4040_0000;
      default: return pick_float_word();
    endcase
  endfunction

  task automatic put_word(input int pos, input logic [31:0] w);
    for (int i = 0; i < WORD_BYTES; i++) frame_buf[pos + i] = w[31 - 8 * i -: 8];
  endtask

  task automatic build_frame(input frame_shape_t shape);
    int         len;
    int         n;
    int         extra;
    int         idx;
    logic [7:0] acc;
    frame_buf.delete();
    case (shape)
      SHAPE_NOISE: begin
        n = $urandom_range(0, FRAME_BYTES + 6);
        repeat (n) frame_buf.push_back(8'($urandom));
        if (n >= 2 && $urandom_range(0, 1) == 1) begin
          frame_buf[POS_HDR0] = HDR_BYTE;
          frame_buf[POS_HDR1] = HDR_BYTE;
        end
      end
      SHAPE_BAD_LEN: begin
        n = $urandom_range(4, 12);
        repeat (n) frame_buf.push_back(8'($urandom));
        frame_buf[POS_HDR0] = HDR_BYTE;
        frame_buf[POS_HDR1] = HDR_BYTE;
        frame_buf[POS_LEN]  = 8'($urandom_range(LEN_MAX + 1, 255));
      end
      default: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
          6, 7:             len = $urandom_range(13, 44);
          8:                len = LEN_MAX;
          default:          len = $urandom_range(44, LEN_MAX);
        endcase
        // Now and then run past the end of the store.
        if ($urandom_range(0, 7) == 0)
          extra = $urandom_range(0, FRAME_BYTES + 6 - (len + 5));
        else
          extra = $urandom_range(0, 3);
        n = len + 5 + extra;
        repeat (n) frame_buf.push_back(8'($urandom));
        frame_buf[POS_HDR0] = HDR_BYTE;
        frame_buf[POS_HDR1] = HDR_BYTE;
        frame_buf[POS_LEN]  = 8'(len);
        if (n >= 8) put_word(POS_START_WORD, pick_float_word());
        if (n >= 12) put_word(POS_START_WORD + WORD_BYTES, pick_mode_word());
        acc = 8'd0;
        for (int i = 0; i < len + SUM_BASE; i++) acc += frame_buf[i];
        frame_buf[len + SUM_BASE] = acc;
        if (shape == SHAPE_BAD_SUM)
          frame_buf[len + SUM_BASE] = acc + 8'($urandom_range(1, 255));
        if (shape == SHAPE_BAD_HDR) begin
          idx = $urandom_range(POS_HDR0, POS_HDR1);
          frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
        end
      end
    endcase
  endtask

  // After reset the store holds zeros, so the header check fails.
  task automatic test_empty_store();
    frame_buf = {};
    send_frame();
  endtask

  // Zero payload: the checksum is the header sum and the words are stale.
  task automatic test_minimal_frame();
    frame_buf = {HDR_BYTE, HDR_BYTE, 8'h00, 8'h00, 8'(HDR_BYTE + HDR_BYTE)};
    send_frame();
  endtask

  task automatic test_bad_header();
    frame_buf = {8'h55, HDR_BYTE};
    send_frame();
    frame_buf = {HDR_BYTE, 8'h2A};
    send_frame();
  endtask

  task automatic test_bad_length();
    frame_buf = {HDR_BYTE, HDR_BYTE, 8'h00, 8'(LEN_MAX + 1)};
    send_frame();
  endtask

  task automatic test_bad_checksum();
    frame_buf = {HDR_BYTE, HDR_BYTE, 8'h00, 8'h00, 8'h55};
    send_frame();
  endtask

  task automatic test_random_frames();
    int           frames;
    int           r;
    frame_shape_t shape;
    frames = 0;
    while (items_taken < RANDOM_ITEMS && frames < 300) begin
      r = $urandom_range(0, 99);
      if (r < 55)      shape = SHAPE_GOOD;
      else if (r < 67) shape = SHAPE_BAD_SUM;
      else if (r < 77) shape = SHAPE_BAD_HDR;
      else if (r < 87) shape = SHAPE_BAD_LEN;
      else             shape = SHAPE_NOISE;
      no_gaps = ($urandom_range(0, 5) == 0);
      build_frame(shape);
      send_frame();
      frames++;
      // Hold off once so the block runs dry before the next frame.
      if (frames == 4) wait_for_drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_BYTE;
    in_ch.rx_byte  = 8'd0;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    items_taken    = 0;
    cycle_count    = 0;
    shadow_pos      = 0;
    shadow_received = 32'd0;
    shadow_valid    = 32'd0;
    shadow_bad      = 32'd0;
    foreach (shadow_store[i]) shadow_store[i] = 8'd0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_minimal_frame();
    test_bad_header();
    test_bad_length();
    test_bad_checksum();
    test_random_frames();

    wait_for_drain();
    if (pending_items.size() != 0)
      report_mismatch($sformatf("%0d predicted words never arrived", pending_items.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_in_if.sv
hw/rtl/cfd_out_if.sv
hw/rtl/cfd_datapath.sv
hw/rtl/cfd_controller.sv
hw/rtl/command_frame_deframer.sv
hw/rtl/cfd_checker.sv
dv/tb_top.sv
